FILE: hdl/lfir_pkg.sv
// ----------------------------------------------------------------------------
// lfir_pkg
// Shared constants, coefficient table and control bundle of the 51-tap
// low-pass FIR core.
// ----------------------------------------------------------------------------
package lfir_pkg;

   localparam int TAPS         = 51;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;

   // bits of the sample fed to the multiplier each cycle
   localparam int DIGIT_WIDTH  = 4;

   localparam int TABLE_LEN    = 51;
   localparam int TABLE_FRAC   = 15;

   localparam logic signed [15:0] COEF_Q15 [TABLE_LEN] = '{
      -16'sd30, -16'sd36, -16'sd38, -16'sd32, -16'sd13, 16'sd23, 16'sd74, 16'sd132,
      16'sd180, 16'sd195, 16'sd154, 16'sd44, -16'sd132, -16'sd350, -16'sd563,
      -16'sd707, -16'sd711, -16'sd514, -16'sd81, 16'sd584, 16'sd1434, 16'sd2380,
      16'sd3307, 16'sd4086, 16'sd4606, 16'sd4789, 16'sd4606, 16'sd4086, 16'sd3307,
      16'sd2380, 16'sd1434, 16'sd584, -16'sd81, -16'sd514, -16'sd711, -16'sd707,
      -16'sd563, -16'sd350, -16'sd132, 16'sd44, 16'sd154, 16'sd195, 16'sd180,
      16'sd132, 16'sd74, 16'sd23, -16'sd13, -16'sd32, -16'sd38, -16'sd36, -16'sd30
   };

   // coefficient of tap k scaled to cw bits, zero beyond the table
   function automatic logic signed [63:0] coef_at(input int unsigned k, input int cw);
      logic signed [63:0] c;
      c = 64'sd0;
      if (k < TABLE_LEN) begin
         c = 64'(COEF_Q15[k]);
         if (cw - 1 >= TABLE_FRAC) begin
            c = c <<< (cw - 1 - TABLE_FRAC);
         end else begin
            // round half up while dropping fraction bits
            c = (c + (64'sd1 <<< (TABLE_FRAC - cw))) >>> (TABLE_FRAC - cw + 1);
         end
      end
      return c;
   endfunction

   typedef struct packed {
      logic load;         // transaction accepted, new sample enters the line
      logic mac_en;       // digit-serial multiply in progress
      logic first_digit;  // most significant (signed) digit of a tap
      logic last_digit;   // least significant digit, tap finishes
      logic clear_line;   // block end: zero the line instead of rotating
      logic emit;         // load the result register
   } lfir_ctrl_type;

endpackage

FILE: hdl/lfir_stream_if.sv
// ----------------------------------------------------------------------------
// lfir_stream_if
// Valid/ready channels carrying samples into and filtered samples out of
// the FIR core.
// ----------------------------------------------------------------------------
interface lfir_req_if #(
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_of_block;

   modport source (output valid, sample, last_of_block, input ready);
   modport sink   (input valid, sample, last_of_block, output ready);
endinterface

interface lfir_rsp_if #(
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] filtered;
   logic                           saturated;

   modport source (output valid, filtered, saturated, input ready);
   modport sink   (input valid, filtered, saturated, output ready);
endinterface

FILE: hdl/lfir_delay_line.sv
// ----------------------------------------------------------------------------
// lfir_delay_line
// Sample delay line as a rotating shift register, newest sample at the
// head, plus the digit shifter that feeds the head sample out MSB first.
// ----------------------------------------------------------------------------
module lfir_delay_line #(
   parameter int TAPS         = lfir_pkg::TAPS,
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lfir_pkg::lfir_ctrl_type         ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
   output logic [lfir_pkg::DIGIT_WIDTH-1:0] digit_out
);

   localparam int DW = lfir_pkg::DIGIT_WIDTH;
   localparam int ND = (SAMPLE_WIDTH + DW - 1) / DW;
   localparam int XW = ND * DW;

   logic signed [SAMPLE_WIDTH-1:0] line_ff [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] line_in [TAPS];
   logic [XW-1:0]                  digit_ff;
   logic [XW-1:0]                  digit_in;

   always_comb begin
      line_in  = line_ff;
      digit_in = digit_ff;
      if (ctrl.load) begin
         line_in[0] = sample_in;
         for (int i = 1; i < TAPS; i++) begin
            line_in[i] = line_ff[i-1];
         end
         digit_in = XW'(sample_in);
      end else if (ctrl.last_digit) begin
         if (ctrl.clear_line) begin
            for (int i = 0; i < TAPS; i++) begin
               line_in[i] = '0;
            end
            digit_in = '0;
         end else begin
            // rotate toward the head; after TAPS steps the line is back in place
            for (int i = 0; i < TAPS - 1; i++) begin
               line_in[i] = line_ff[i+1];
            end
            line_in[TAPS-1] = line_ff[0];
            digit_in = XW'(line_ff[1]);
         end
      end else if (ctrl.mac_en) begin
         digit_in = digit_ff << DW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff[XW-1 -: DW];

endmodule

FILE: hdl/lfir_mac.sv
// ----------------------------------------------------------------------------
// lfir_mac
// Digit-serial multiplier (coefficient times one sample digit per cycle,
// Horner order) and the wide accumulator of the tap products.
// ----------------------------------------------------------------------------
module lfir_mac #(
   parameter int TAPS         = lfir_pkg::TAPS,
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = lfir_pkg::COEF_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lfir_pkg::lfir_ctrl_type                ctrl,
   input  logic signed [COEF_WIDTH-1:0]           coef,
   input  logic [lfir_pkg::DIGIT_WIDTH-1:0]       digit,
   output logic signed [SAMPLE_WIDTH+COEF_WIDTH+$clog2(TAPS)-1:0] acc_out
);

   localparam int DW = lfir_pkg::DIGIT_WIDTH;
   localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int AW = PW + $clog2(TAPS);
   localparam int MW = COEF_WIDTH + DW + 1;

   // rounding half of the final shift is preloaded into the accumulator
   localparam logic signed [AW-1:0] ACC_INIT = AW'(64'sd1 <<< (COEF_WIDTH - 2));

   logic signed [DW:0]   digit_val;
   logic signed [MW-1:0] part;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] acc_in;
   logic                 add_pending_ff;

   always_comb begin
      // top digit carries the sign, the rest are plain magnitudes
      digit_val = ctrl.first_digit ? $signed({digit[DW-1], digit}) : $signed({1'b0, digit});
      part      = coef * digit_val;
      prod_in   = prod_ff;
      if (ctrl.mac_en) begin
         prod_in = (ctrl.first_digit ? PW'(0) : (prod_ff <<< DW)) + PW'(part);
      end
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = ACC_INIT;
      end else if (add_pending_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_pending_ff <= 1'b0;
      end else begin
         add_pending_ff <= ctrl.last_digit;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc_out = acc_ff;

endmodule

FILE: hdl/lfir_out_stage.sv
// ----------------------------------------------------------------------------
// lfir_out_stage
// Drops the fraction bits of the accumulator, saturates to the sample range
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module lfir_out_stage #(
   parameter int TAPS         = lfir_pkg::TAPS,
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = lfir_pkg::COEF_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lfir_pkg::lfir_ctrl_type                ctrl,
   input  logic signed [SAMPLE_WIDTH+COEF_WIDTH+$clog2(TAPS)-1:0] acc_in,
   output logic                                   busy,
   lfir_rsp_if.source                             rsp_chan
);

   localparam int AW = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAPS);
   localparam int YW = AW - COEF_WIDTH + 1;

   localparam logic signed [YW-1:0] MAX_Y = YW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [YW-1:0] MIN_Y = YW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

   logic signed [YW-1:0]           y_wide;
   logic                           over_hi;
   logic                           over_lo;
   logic signed [SAMPLE_WIDTH-1:0] filtered_ff;
   logic signed [SAMPLE_WIDTH-1:0] filtered_in;
   logic                           saturated_ff;
   logic                           valid_ff;

   always_comb begin
      // accumulator already holds the rounding half, so a floor shift rounds
      y_wide  = YW'(acc_in >>> (COEF_WIDTH - 1));
      over_hi = y_wide > MAX_Y;
      over_lo = y_wide < MIN_Y;
      if (over_hi) begin
         filtered_in = MAX_Y[SAMPLE_WIDTH-1:0];
      end else if (over_lo) begin
         filtered_in = MIN_Y[SAMPLE_WIDTH-1:0];
      end else begin
         filtered_in = y_wide[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.emit | (valid_ff & ~rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         filtered_ff  <= filtered_in;
         saturated_ff <= over_hi | over_lo;
      end
   end

   assign busy               = valid_ff & ~rsp_chan.ready;
   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.filtered  = filtered_ff;
   assign rsp_chan.saturated = saturated_ff;

endmodule

FILE: hdl/lowpass_fir_51_tap_core.sv
// ----------------------------------------------------------------------------
// lowpass_fir_51_tap_core
// 51-tap symmetric low-pass FIR on signed Q1.15 samples, digit-serial.
//
// req_chan carries one sample and a block-end mark per transaction; rsp_chan
// returns one filtered Q1.15 sample with a saturation flag per transaction.
// Each tap is multiplied four sample bits per cycle against a fixed
// coefficient; the multiply loop runs over all digits of all taps.
// The result then passes the drain and emit states into the output
// register, and the next sample is taken only after that, so the core
// handles one sample at a time. req_chan.ready is high only between
// samples, and it also stays low while a finished result waits for the
// output register to free up. A finished result sits in the output
// register; when the receiver stalls, the following sample still
// computes and then waits for the register to free up.
// Reset zeroes the delay line and drops any pending result. A block-end
// mark zeroes the delay line once that sample's result is formed.
// ----------------------------------------------------------------------------
module lowpass_fir_51_tap_core #(
   parameter int TAPS         = lfir_pkg::TAPS,
   parameter int SAMPLE_WIDTH = lfir_pkg::SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = lfir_pkg::COEF_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   lfir_req_if.sink   req_chan,
   lfir_rsp_if.source rsp_chan
);

   localparam int DW  = lfir_pkg::DIGIT_WIDTH;
   localparam int ND  = (SAMPLE_WIDTH + DW - 1) / DW;
   localparam int DCW = (ND > 1) ? $clog2(ND) : 1;
   localparam int TCW = $clog2(TAPS);
   localparam int AW  = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAPS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic [DCW-1:0]               digit_cnt_ff;
   logic [DCW-1:0]               digit_cnt_in;
   logic [TCW-1:0]               tap_cnt_ff;
   logic [TCW-1:0]               tap_cnt_in;
   logic                         last_block_ff;
   logic                         last_block_in;
   logic                         accept;
   logic                         last_dig;
   logic                         last_tap;
   logic                         out_busy;
   logic signed [COEF_WIDTH-1:0] coef;
   logic [DW-1:0]                digit;
   logic signed [AW-1:0]         acc;
   lfir_pkg::lfir_ctrl_type      ctrl;

   assign accept   = req_chan.valid & req_chan.ready;
   assign last_dig = digit_cnt_ff == DCW'(ND - 1);
   assign last_tap = tap_cnt_ff == TCW'(TAPS - 1);

   always_comb begin
      state_in      = state_ff;
      digit_cnt_in  = digit_cnt_ff;
      tap_cnt_in    = tap_cnt_ff;
      last_block_in = last_block_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_MAC;
               digit_cnt_in  = '0;
               tap_cnt_in    = '0;
               last_block_in = req_chan.last_of_block;
            end
         end
         ST_MAC: begin
            if (last_dig) begin
               digit_cnt_in = '0;
               if (last_tap) begin
                  tap_cnt_in = '0;
                  state_in   = ST_DRAIN;
               end else begin
                  tap_cnt_in = tap_cnt_ff + 1'b1;
               end
            end else begin
               digit_cnt_in = digit_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.load        = accept;
      ctrl.mac_en      = state_ff == ST_MAC;
      ctrl.first_digit = (state_ff == ST_MAC) && (digit_cnt_ff == '0);
      ctrl.last_digit  = (state_ff == ST_MAC) && last_dig;
      ctrl.clear_line  = (state_ff == ST_MAC) && last_dig && last_tap && last_block_ff;
      ctrl.emit        = (state_ff == ST_EMIT) && !out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         digit_cnt_ff  <= '0;
         tap_cnt_ff    <= '0;
         last_block_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         digit_cnt_ff  <= digit_cnt_in;
         tap_cnt_ff    <= tap_cnt_in;
         last_block_ff <= last_block_in;
      end
   end

   assign req_chan.ready = state_ff == ST_IDLE;

   // coefficient rom indexed by the tap counter
   assign coef = COEF_WIDTH'(lfir_pkg::coef_at(32'(tap_cnt_ff), COEF_WIDTH));

   lfir_delay_line #(
      .TAPS         (TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .sample_in (req_chan.sample),
      .digit_out (digit)
   );

   lfir_mac #(
      .TAPS         (TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .coef    (coef),
      .digit   (digit),
      .acc_out (acc)
   );

   lfir_out_stage #(
      .TAPS         (TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .acc_in   (acc),
      .busy     (out_busy),
      .rsp_chan (rsp_chan)
   );

   // counters rest at zero between samples
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> digit_cnt_ff == '0 && tap_cnt_ff == '0)
      else $error("tap or digit counter not at zero while idle");

   // a transaction always starts the multiply loop
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MAC && ctrl.first_digit)
      else $error("accepted sample did not start the multiply loop");

   // a finished result reaches the output register the next cycle
   assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |=> rsp_chan.valid)
      else $error("result was not presented after emit");

   // the line is only cleared on the very last digit of the last tap
   assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_line |=> state_ff == ST_DRAIN)
      else $error("delay line cleared before all taps were read");

endmodule

FILE: tb/tb_lowpass_fir_51_tap_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowpass_fir_51_tap_core
// Self-checking bench for the 51-tap low-pass FIR core. Samples go in over
// the request channel with random gaps. A behavioral copy of the filter
// (circular tap line, exact accumulation, round half up, clip) predicts every
// output, and each result transaction is compared against it in order.
// Directed extremes, block ends and clipping come first. Then random passages
// run: noise, quiet, loud, dc and sparse. One long receiver hold backs the
// core up.
// ----------------------------------------------------------------------------
module tb_lowpass_fir_51_tap_core;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int ITEM_CYCLES  = lfir_pkg::TAPS * 4 + 3;
   localparam int DRAIN_CYCLES = 2 * ITEM_CYCLES;
   localparam int HOLD_CYCLES  = 3000;
   localparam int RANDOM_ITEMS = 500;
   localparam int MAX_REPORTS  = 200;

   typedef logic signed [lfir_pkg::SAMPLE_WIDTH-1:0] sample_type;

   localparam sample_type FULL_POS = 16'sh7fff;
   localparam sample_type FULL_NEG = 16'sh8000;

   // first half of the symmetric low-pass set, center tap last
   localparam int FIR_HALF [26] = '{
      -30, -36, -38, -32, -13, 23, 74, 132, 180, 195, 154, 44, -132,
      -350, -563, -707, -711, -514, -81, 584, 1434, 2380, 3307, 4086, 4606,
      4789
   };

   typedef enum int {
      PASSAGE_NOISE,
      PASSAGE_QUIET,
      PASSAGE_LOUD,
      PASSAGE_DC,
      PASSAGE_SPARSE
   } passage_type;

   typedef struct packed {
      sample_type filtered;
      logic       saturated;
   } filter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfir_req_if req_if ();
   lfir_rsp_if rsp_if ();

   lowpass_fir_51_tap_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // filter state mirrored by the bench
   sample_type     tap_line [lfir_pkg::TAPS];
   int unsigned    line_pos;
   filter_out_type pending_out [$];

   int error_count    = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int clipped_seen   = 0;
   int block_ends     = 0;
   int line_wraps     = 0;
   bit req_jitter     = 1'b0;
   bit rsp_jitter     = 1'b0;
   int rsp_hold_request = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
         $display("tb_lowpass_fir_51_tap_core failed");
         $finish;
      end
   end

   function automatic int coef_of(input int k);
      return (k <= lfir_pkg::TAPS / 2) ? FIR_HALF[k] : FIR_HALF[lfir_pkg::TAPS - 1 - k];
   endfunction

   // one filter step: store sample, sum over taps, round, clip, advance, clear on block end
   function automatic filter_out_type filter_step(input sample_type s, input logic lob);
      longint         acc;
      longint         y;
      int unsigned    idx;
      filter_out_type r;
      tap_line[line_pos] = s;
      acc = 0;
      for (int k = 0; k < lfir_pkg::TAPS; k++) begin
         idx = (line_pos + lfir_pkg::TAPS - k) % lfir_pkg::TAPS;
         acc += longint'(coef_of(k)) * longint'(tap_line[idx]);
      end
      y = (acc + 64'sd16384) >>> 15;
      r.saturated = 1'b0;
      if (y > 32767) begin
         r.filtered  = FULL_POS;
         r.saturated = 1'b1;
      end else if (y < -32768) begin
         r.filtered  = FULL_NEG;
         r.saturated = 1'b1;
      end else begin
         r.filtered = sample_type'(y);
      end
      line_pos = (line_pos + 1) % lfir_pkg::TAPS;
      if (line_pos == 0 && !lob) line_wraps++;
      if (lob) begin
         foreach (tap_line[i]) tap_line[i] = '0;
         line_pos = 0;
      end
      return r;
   endfunction

   // mostly short, a few long enough to let the core sit idle
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 20);
      else return $urandom_range(30, 400);
   endfunction

   task automatic send_sample(input sample_type s, input logic lob);
      int gap;
      gap = req_jitter ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid         <= 1'b0;
         req_if.sample        <= sample_type'($urandom);
         req_if.last_of_block <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.sample        <= s;
      req_if.last_of_block <= lob;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_out.push_back(filter_step(s, lob));
      items_sent++;
      if (lob) block_ends++;
   endtask

   // result side: stalls, the long hold, and the in-order compare
   initial begin : result_monitor
      int             stall_left;
      filter_out_type want;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_out.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: result with nothing expected: filtered=%0d saturated=%0b",
                           $time, rsp_if.filtered, rsp_if.saturated);
            end else begin
               want = pending_out.pop_front();
               results_seen++;
               if (want.saturated) clipped_seen++;
               if (rsp_if.filtered !== want.filtered) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: filtered mismatch: expected %0d, actual %0d",
                              $time, want.filtered, rsp_if.filtered);
               end
               if (rsp_if.saturated !== want.saturated) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: saturated mismatch: expected %0b, actual %0b",
                              $time, want.saturated, rsp_if.saturated);
               end
            end
         end
         if (rsp_hold_request > 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && rsp_jitter && $urandom_range(7) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic test_extremes_and_block_end();
      req_jitter = 1'b0;
      rsp_jitter = 1'b0;
      send_sample(FULL_POS, 1'b0);
      send_sample('0, 1'b0);
      send_sample('0, 1'b0);
      send_sample(FULL_NEG, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shaaaa, 1'b0);
      send_sample(16'sh0001, 1'b0);
      // block end: line is cleared after this result
      send_sample(16'shffff, 1'b1);
      send_sample(16'sh0064, 1'b0);
      send_sample(FULL_NEG, 1'b1);
   endtask

   // signs matched to the first 28 taps push the sum past full scale
   task automatic test_positive_overflow();
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
      for (int n = 0; n < 28; n++)
         send_sample((coef_of(27 - n) >= 0) ? FULL_POS : FULL_NEG, n == 27);
   endtask

   task automatic test_back_pressure();
      req_jitter       = 1'b0;
      rsp_jitter       = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      for (int n = 0; n < 8; n++)
         send_sample(sample_type'($urandom), 1'b0);
   endtask

   task automatic test_random_passages();
      passage_type style;
      int          len;
      int          sent;
      int          tap;
      int          mag;
      bit          end_mark;
      bit          polarity;
      bit          neg;
      sample_type  level;
      sample_type  s;
      logic        lob;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(9)) inside
            [0:2]:   style = PASSAGE_NOISE;
            3:       style = PASSAGE_QUIET;
            [4:6]:   style = PASSAGE_LOUD;
            7:       style = PASSAGE_DC;
            default: style = PASSAGE_SPARSE;
         endcase
         len      = (style == PASSAGE_LOUD) ? $urandom_range(51, 70) : $urandom_range(5, 80);
         end_mark = ($urandom_range(2) == 0);
         polarity = 1'($urandom);
         level    = sample_type'($urandom);
         // some passages run with no idling on either side
         req_jitter = ($urandom_range(4) != 0);
         rsp_jitter = ($urandom_range(4) != 0);
         for (int n = 0; n < len; n++) begin
            lob = end_mark && (n == len - 1);
            case (style)
               PASSAGE_NOISE: begin
                  s = sample_type'($urandom);
                  if ($urandom_range(39) == 0) lob = 1'b1;
               end
               PASSAGE_QUIET: s = sample_type'(int'($urandom_range(511)) - 256);
               PASSAGE_LOUD: begin
                  tap = len - 1 - n;
                  mag = $urandom_range(20000, 32767);
                  neg = (tap < lfir_pkg::TAPS) ? ((coef_of(tap) < 0) ^ polarity)
                                               : 1'($urandom);
                  s   = neg ? sample_type'(-mag - int'(mag == 32767)) : sample_type'(mag);
               end
               PASSAGE_DC: s = level;
               default: s = ($urandom_range(9) == 0) ? sample_type'($urandom) : '0;
            endcase
            send_sample(s, lob);
            sent++;
         end
      end
   endtask

   task automatic finish_run();
      req_if.valid <= 1'b0;
      rsp_jitter = 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      // anything arriving now is a stray result
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d samples, checked %0d results, %0d clipped", items_sent, results_seen,
               clipped_seen);
      $display("%0d block ends, %0d tap line wraps, one %0d-cycle receiver hold",
               block_ends, line_wraps, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("tb_lowpass_fir_51_tap_core passed");
      end else begin
         $display("tb_lowpass_fir_51_tap_core failed");
      end
      $finish;
   endtask

   initial begin
      req_if.valid         = 1'b0;
      req_if.sample        = '0;
      req_if.last_of_block = 1'b0;
      foreach (tap_line[i]) tap_line[i] = '0;
      line_pos = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_extremes_and_block_end();
      test_positive_overflow();
      test_back_pressure();
      test_random_passages();
      finish_run();
   end

endmodule
